FILE: src/usmsw_pkg.sv
package usmsw_pkg;

  // USB-MIDI code index values
  localparam logic [3:0] CI_SYSEX_CONT = 4'h4;
  localparam logic [3:0] CI_END1       = 4'h5;
  localparam logic [3:0] CI_END2       = 4'h6;
  localparam logic [3:0] CI_END3       = 4'h7;
  localparam logic [3:0] CI_PRESSURE   = 4'hD;

  // sysex framing and strip message header
  localparam logic [7:0] SYSEX_START   = 8'hF0;
  localparam logic [7:0] SYSEX_END     = 8'hF7;
  localparam logic [7:0] STRIP_CMD     = 8'h12;
  localparam int         MIN_STRIP_LEN = 8;
  localparam int         FIRST_DATA    = 7;

  // result kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_LEVEL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRESS,
    ST_STORE,
    ST_CHECK,
    ST_SCAN
  } usmsw_state_t;

  typedef enum logic [1:0] {
    PK_OTHER,
    PK_PRESS,
    PK_SYSEX
  } pkt_kind_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // latch an accepted packet
    logic press;  // load a level update into the output register
    logic store;  // write one packet byte to the store
    logic check;  // message closed: set up the scan
    logic scan;   // scan step
  } usmsw_cmd_t;

  // datapath to controller
  typedef struct packed {
    pkt_kind_t in_kind;
    logic      store_last;
    logic      closing;
    logic      strip_msg;
    logic      out_free;
    logic      scan_done;
  } usmsw_stat_t;

  function automatic pkt_kind_t decode_code(logic [3:0] ci);
    pkt_kind_t k;
    unique case (ci)
      CI_PRESSURE:                                    k = PK_PRESS;
      CI_SYSEX_CONT, CI_END1, CI_END2, CI_END3:       k = PK_SYSEX;
      default:                                        k = PK_OTHER;
    endcase
    return k;
  endfunction

  // index of the last data byte a sysex packet carries
  function automatic logic [1:0] last_byte_sel(logic [3:0] ci);
    logic [1:0] s;
    unique case (ci)
      CI_END1: s = 2'd0;
      CI_END2: s = 2'd1;
      default: s = 2'd2;
    endcase
    return s;
  endfunction

endpackage

FILE: src/usmsw_in_if.sv
interface usmsw_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] code_index;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;

  modport source (output valid, output code_index, output first_byte,
                  output second_byte, output third_byte, input ready);
  modport sink   (input valid, input code_index, input first_byte,
                  input second_byte, input third_byte, output ready);
endinterface

FILE: src/usmsw_out_if.sv
interface usmsw_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [6:0] strip_address;
  logic [7:0] strip_value;
  logic [2:0] channel;
  logic [3:0] level;
  logic       last;

  modport source (output valid, output kind, output strip_address, output strip_value,
                  output channel, output level, output last, input ready);
  modport sink   (input valid, input kind, input strip_address, input strip_value,
                  input channel, input level, input last, output ready);
endinterface

FILE: src/usmsw_ctrl.sv
module usmsw_ctrl
  import usmsw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  usmsw_stat_t stat,
  output usmsw_cmd_t  cmd
);

  usmsw_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (stat.in_kind)
            PK_PRESS: state_nxt = ST_PRESS;
            PK_SYSEX: state_nxt = ST_STORE;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PRESS: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      ST_STORE: begin
        if (stat.store_last) state_nxt = stat.closing ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        state_nxt = stat.strip_msg ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (stat.scan_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    cmd.load  = (state_r == ST_IDLE) && in_valid;
    cmd.press = (state_r == ST_PRESS) && stat.out_free;
    cmd.store = (state_r == ST_STORE);
    cmd.check = (state_r == ST_CHECK);
    cmd.scan  = (state_r == ST_SCAN);
  end

endmodule

FILE: src/usmsw_dp.sv
module usmsw_dp
  import usmsw_pkg::*;
#(
  parameter int STORE_DEPTH = 64,
  parameter int STRIP_BYTES = 112
) (
  input  logic        clk,
  input  logic        rst_n,
  input  usmsw_cmd_t  cmd,
  output usmsw_stat_t stat,
  input  logic [3:0]  in_code_index,
  input  logic [7:0]  in_first_byte,
  input  logic [7:0]  in_second_byte,
  input  logic [7:0]  in_third_byte,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        out_kind,
  output logic [6:0]  out_strip_address,
  output logic [7:0]  out_strip_value,
  output logic [2:0]  out_channel,
  output logic [3:0]  out_level,
  output logic        out_last
);

  localparam int FILL_W = $clog2(STORE_DEPTH + 1);
  localparam int IDX_W  = $clog2(STORE_DEPTH);
  localparam int ADDR_W = 9;  // base byte plus offset into the store

  // latched packet
  logic [3:0] code_r;
  logic [7:0] b1_r, b2_r, b3_r;
  logic [1:0] sel_r, j_r;

  // message state
  logic              accum_r;
  logic [FILL_W-1:0] fill_r;
  logic [7:0]        hdr0_r, hdr5_r, base_r;
  logic [7:0]        mem [STORE_DEPTH];

  // scan state
  logic [FILL_W-1:0] rd_idx_r;
  logic [ADDR_W-1:0] rd_addr_r, data_addr_r;
  logic [7:0]        rdata_r;
  logic              rdv_r;
  logic              cand_v_r;
  logic [6:0]        cand_addr_r;
  logic [7:0]        cand_val_r;

  // output register
  logic       out_valid_r, out_kind_r, out_last_r;
  logic [6:0] out_addr_r;
  logic [7:0] out_val_r;
  logic [2:0] out_chan_r;
  logic [3:0] out_lvl_r;

  logic [7:0] wbyte;
  logic       we, re, out_free, go, term, more, finish, push_write;
  pkt_kind_t  in_kind;

  assign in_kind  = decode_code(in_code_index);
  assign out_free = !out_valid_r || out_ready;

  // byte of the packet in flight
  always_comb begin
    unique case (j_r)
      2'd0:    wbyte = b1_r;
      2'd1:    wbyte = b2_r;
      default: wbyte = b3_r;
    endcase
  end

  assign we = cmd.store && (fill_r < FILL_W'(STORE_DEPTH));

  // scan control: one store byte a cycle, held while the output is full
  assign go         = cmd.scan && out_free;
  assign term       = rdv_r && ((rdata_r == SYSEX_END) ||
                                (data_addr_r >= ADDR_W'(STRIP_BYTES)));
  assign more       = rd_idx_r < fill_r;
  assign finish     = term || (!rdv_r && !more);
  assign re         = go && !finish && more;
  assign push_write = go && cand_v_r && (finish || rdv_r);

  // packet latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_r <= in_code_index;
      b1_r   <= in_first_byte;
      b2_r   <= in_second_byte;
      b3_r   <= in_third_byte;
      sel_r  <= last_byte_sel(in_code_index);
      j_r    <= 2'd0;
    end else if (cmd.store) begin
      j_r <= j_r + 2'd1;
    end
  end

  // accumulation flag and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= 1'b0;
      fill_r  <= '0;
    end else begin
      if (cmd.load && (in_kind == PK_SYSEX)) begin
        if (!accum_r) fill_r <= '0;
        accum_r <= (in_code_index == CI_SYSEX_CONT);
      end else if (we) begin
        fill_r <= fill_r + FILL_W'(1);
      end
    end
  end

  // header bytes kept beside the store
  always_ff @(posedge clk) begin
    if (we) begin
      if (fill_r == FILL_W'(0)) hdr0_r <= wbyte;
      if (fill_r == FILL_W'(5)) hdr5_r <= wbyte;
      if (fill_r == FILL_W'(6)) base_r <= wbyte;
    end
  end

  // message store, registered read
  always_ff @(posedge clk) begin
    if (we) mem[fill_r[IDX_W-1:0]] <= wbyte;
    if (re) rdata_r <= mem[rd_idx_r[IDX_W-1:0]];
  end

  // scan pointers and address tracking
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      rd_idx_r  <= FILL_W'(FIRST_DATA);
      rd_addr_r <= {1'b0, base_r};
    end else if (re) begin
      rd_idx_r    <= rd_idx_r + FILL_W'(1);
      rd_addr_r   <= rd_addr_r + ADDR_W'(1);
      data_addr_r <= rd_addr_r;
    end
  end

  // pending write, held back until its successor decides the last flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r    <= 1'b0;
      cand_v_r <= 1'b0;
    end else if (cmd.check) begin
      rdv_r    <= 1'b0;
      cand_v_r <= 1'b0;
    end else if (go) begin
      rdv_r <= re;
      if (rdv_r && !term) cand_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (go && rdv_r && !term) begin
      cand_addr_r <= data_addr_r[6:0];
      cand_val_r  <= rdata_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.press || push_write) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.press) begin
      out_kind_r <= KIND_LEVEL;
      out_addr_r <= '0;
      out_val_r  <= '0;
      out_chan_r <= b2_r[6:4];
      out_lvl_r  <= b2_r[3:0];
      out_last_r <= 1'b1;
    end else if (push_write) begin
      out_kind_r <= KIND_WRITE;
      out_addr_r <= cand_addr_r;
      out_val_r  <= cand_val_r;
      out_chan_r <= '0;
      out_lvl_r  <= '0;
      out_last_r <= finish;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_strip_address = out_addr_r;
  assign out_strip_value   = out_val_r;
  assign out_channel       = out_chan_r;
  assign out_level         = out_lvl_r;
  assign out_last          = out_last_r;

  // status
  always_comb begin
    stat.in_kind    = in_kind;
    stat.store_last = (j_r == sel_r);
    stat.closing    = (code_r == CI_END1) || (code_r == CI_END2) || (code_r == CI_END3);
    stat.strip_msg  = (fill_r >= FILL_W'(MIN_STRIP_LEN)) && (hdr0_r == SYSEX_START) &&
                      (hdr5_r == STRIP_CMD);
    stat.out_free   = out_free;
    stat.scan_done  = go && finish;
  end

endmodule

FILE: src/usb_midi_sysex_strip_writer.sv
// USB-MIDI sysex reassembly into control-strip writes and peak-level updates.
// in_ch carries one USB-MIDI event packet per transfer (code index and three
// data bytes); out_ch carries results: strip byte writes or level updates,
// with last set on the final result a packet causes.
// The block takes one packet at a time; in_ch.ready is high only when idle.
// Steps per packet once accepted:
//   channel pressure: a press step, held while out_ch is full.
//   sysex start/continue/end: one store step per byte in the packet (1 to 3).
//   closing a strip message: a header check, then a scan of the stored bytes
//   from index 7 on through the single store read port, held on a stall.
// Other packets are accepted and cause nothing.
// Writes reach out_ch one per cycle while it is not stalled, passing from the
// read data register through a held-back write register to the output
// register, since each waits for the next byte to settle its last flag.
// Reset clears the message state and the output register; the store itself
// needs no clearing. A stall on out_ch freezes the scan until the waiting
// result is taken; nothing is dropped.
module usb_midi_sysex_strip_writer
  import usmsw_pkg::*;
#(
  parameter int STORE_DEPTH = 64,
  parameter int STRIP_BYTES = 112
) (
  input  logic        clk,
  input  logic        rst_n,
  usmsw_in_if.sink    in_ch,
  usmsw_out_if.source out_ch
);

  usmsw_cmd_t  cmd;
  usmsw_stat_t stat;
  logic        in_ready;

  usmsw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  usmsw_dp #(
    .STORE_DEPTH (STORE_DEPTH),
    .STRIP_BYTES (STRIP_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_code_index     (in_ch.code_index),
    .in_first_byte     (in_ch.first_byte),
    .in_second_byte    (in_ch.second_byte),
    .in_third_byte     (in_ch.third_byte),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_kind          (out_ch.kind),
    .out_strip_address (out_ch.strip_address),
    .out_strip_value   (out_ch.strip_value),
    .out_channel       (out_ch.channel),
    .out_level         (out_ch.level),
    .out_last          (out_ch.last)
  );

  assign in_ch.ready = in_ready;

  // a level update is always the only result of its packet
  a_level_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.kind == KIND_LEVEL)) |-> out_ch.last)
    else $error("level update without last flag");

  // strip writes never land outside the strip
  a_strip_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.kind == KIND_WRITE)) |->
      (int'(out_ch.strip_address) < STRIP_BYTES))
    else $error("strip write beyond strip size");

  // a pressure packet holds off the next transfer for its update cycle
  a_press_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.code_index == CI_PRESSURE)) |=> !in_ch.ready)
    else $error("input taken while level update pending");

endmodule

FILE: dv/usmsw_result_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the sysex strip writer, predicts the results of
// every accepted packet and compares each result transfer with the oldest
// prediction.
module usmsw_result_checker
  import usmsw_pkg::*;
#(
  parameter int STORE_DEPTH = 64,
  parameter int STRIP_BYTES = 112
) (
  input  logic clk,
  input  logic rst_n,
  usmsw_in_if  in_ch,
  usmsw_out_if out_ch,
  output int   fail_count,
  output int   expected_left
);

  typedef struct packed {
    logic       kind;
    logic [6:0] strip_address;
    logic [7:0] strip_value;
    logic [2:0] channel;
    logic [3:0] level;
    logic       last;
  } strip_result_t;

  strip_result_t pending_results[$];

  // sysex reassembly state
  logic       msg_open;
  logic [7:0] msg_bytes [STORE_DEPTH];
  int         msg_len;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] result error: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // bytes past the store depth are dropped, the message goes on
  function automatic void append_byte(input logic [7:0] b);
    if (msg_len < STORE_DEPTH) begin
      msg_bytes[msg_len] = b;
      msg_len++;
    end
  endfunction

  // closed message: strip writes from index 7 up to the terminator
  function automatic void close_message();
    strip_result_t r;
    int            idx;
    int            addr;
    int            first_new;
    msg_open = 1'b0;
    if (msg_len < MIN_STRIP_LEN) return;
    if (msg_bytes[0] != SYSEX_START || msg_bytes[5] != STRIP_CMD) return;
    first_new = pending_results.size();
    for (idx = FIRST_DATA; idx < msg_len; idx++) begin
      if (msg_bytes[idx] == SYSEX_END) break;
      addr = int'(msg_bytes[6]) + idx - FIRST_DATA;
      // writes beyond the strip are dropped silently
      if (addr < STRIP_BYTES) begin
        r = '0;
        r.kind          = KIND_WRITE;
        r.strip_address = addr[6:0];
        r.strip_value   = msg_bytes[idx];
        pending_results.push_back(r);
      end
    end
    if (pending_results.size() > first_new) begin
      r = pending_results.pop_back();
      r.last = 1'b1;
      pending_results.push_back(r);
    end
  endfunction

  function automatic void predict_packet(input logic [3:0] code, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3);
    strip_result_t r;
    case (code)
      CI_PRESSURE: begin
        r = '0;
        r.kind    = KIND_LEVEL;
        r.channel = b2[6:4];
        r.level   = b2[3:0];
        r.last    = 1'b1;
        pending_results.push_back(r);
      end
      CI_SYSEX_CONT: begin
        if (!msg_open) msg_len = 0;
        append_byte(b1);
        append_byte(b2);
        append_byte(b3);
        msg_open = 1'b1;
      end
      CI_END1, CI_END2, CI_END3: begin
        // an end packet while idle forms a message of its own
        if (!msg_open) msg_len = 0;
        append_byte(b1);
        if (code != CI_END1) append_byte(b2);
        if (code == CI_END3) append_byte(b3);
        close_message();
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    strip_result_t want;
    if (!rst_n) begin
      msg_open = 1'b0;
      msg_len  = 0;
      pending_results.delete();
    end else begin
      // result transfer
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d addr 0x%0h value 0x%0h",
                                    out_ch.kind, out_ch.strip_address, out_ch.strip_value));
        end else begin
          want = pending_results.pop_front();
          check_field("kind", out_ch.kind, want.kind);
          check_field("strip_address", out_ch.strip_address, want.strip_address);
          check_field("strip_value", out_ch.strip_value, want.strip_value);
          check_field("channel", out_ch.channel, want.channel);
          check_field("level", out_ch.level, want.level);
          check_field("last", out_ch.last, want.last);
        end
      end
      // packet transfer
      if (in_ch.valid && in_ch.ready)
        predict_packet(in_ch.code_index, in_ch.first_byte, in_ch.second_byte,
                       in_ch.third_byte);
    end
    expected_left = pending_results.size();
  end

endmodule

FILE: dv/tb_usb_midi_sysex_strip_writer.sv
`timescale 1ns / 100ps

module tb_usb_midi_sysex_strip_writer;
  import usmsw_pkg::*;

  localparam int STORE_DEPTH  = 64;
  localparam int STRIP_BYTES  = 112;
  localparam int RANDOM_ITEMS = 120;
  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 3000000;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst_n;
  int   fail_count;
  int   expected_left;
  int   cycle_count;
  int   packets_sent;
  bit   calm;
  bit   hold_req;

  usmsw_in_if  in_ch ();
  usmsw_out_if out_ch ();

  usb_midi_sysex_strip_writer #(
    .STORE_DEPTH(STORE_DEPTH),
    .STRIP_BYTES(STRIP_BYTES)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  usmsw_result_checker #(
    .STORE_DEPTH(STORE_DEPTH),
    .STRIP_BYTES(STRIP_BYTES)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .expected_left(expected_left)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  // timeout
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // mostly short gaps, a few long ones; none in a calm stretch
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        stall_left = gap_len();
        if (stall_left > 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // one packet transfer, then a random gap; called and left at a falling edge
  task automatic send_packet(input logic [3:0] code, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3);
    int gap;
    in_ch.valid       <= 1'b1;
    in_ch.code_index  <= code;
    in_ch.first_byte  <= b1;
    in_ch.second_byte <= b2;
    in_ch.third_byte  <= b3;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    packets_sent++;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_pressure();
    send_packet(CI_PRESSURE, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // a packet with a code index the block ignores
  task automatic send_noise();
    logic [3:0] c;
    c = 4'($urandom_range(0, 15));
    while (c == CI_SYSEX_CONT || c == CI_END1 || c == CI_END2 || c == CI_END3 ||
           c == CI_PRESSURE)
      c = 4'($urandom_range(0, 15));
    send_packet(c, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // split a byte stream into start/continue packets and one end packet;
  // mixed puts pressure or noise packets between the pieces
  task automatic send_sysex(input byte_q_t bytes, input bit mixed);
    int         pos;
    int         left;
    logic [3:0] code;
    logic [7:0] c0, c1, c2;
    pos = 0;
    while (bytes.size() - pos > 3) begin
      send_packet(CI_SYSEX_CONT, bytes[pos], bytes[pos+1], bytes[pos+2]);
      pos += 3;
      if (mixed && $urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 1) == 0) send_pressure();
        else send_noise();
      end
    end
    left = bytes.size() - pos;
    c0 = bytes[pos];
    c1 = (left > 1) ? bytes[pos+1] : 8'($urandom);
    c2 = (left > 2) ? bytes[pos+2] : 8'($urandom);
    case (left)
      1:       code = CI_END1;
      2:       code = CI_END2;
      default: code = CI_END3;
    endcase
    send_packet(code, c0, c1, c2);
  endtask

  // strip message: F0, four header bytes, command, base address, data,
  // optional terminator
  function automatic byte_q_t strip_message(input int base, input int ndata,
                                            input bit terminate, input bit bad_header);
    byte_q_t q;
    int      i;
    q.push_back((bad_header && $urandom_range(0, 1)) ? 8'($urandom_range(0, 255))
                                                      : SYSEX_START);
    for (i = 0; i < 4; i++) q.push_back(8'($urandom_range(0, 127)));
    q.push_back((bad_header && q[0] == SYSEX_START) ? 8'($urandom_range(0, 17))
                                                     : STRIP_CMD);
    q.push_back(base[7:0]);
    for (i = 0; i < ndata; i++)
      q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127)));
    if (terminate) q.push_back(SYSEX_END);
    return q;
  endfunction

  task automatic send_random_message(input bit mixed);
    int r;
    int ndata;
    int base;
    r = $urandom_range(0, 99);
    if (r < 85)      ndata = $urandom_range(1, 8);
    else if (r < 95) ndata = $urandom_range(9, 30);
    else             ndata = $urandom_range(31, 65);
    r = $urandom_range(0, 99);
    if (r < 70)      base = $urandom_range(0, 105);
    else if (r < 90) base = $urandom_range(100, 115);
    else             base = $urandom_range(0, 255);
    send_sysex(strip_message(base, ndata, $urandom_range(0, 99) < 85,
                             $urandom_range(0, 9) == 0), mixed);
  endtask

  // sender pause until every predicted result has been taken
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_left != 0) @(negedge clk);
  endtask

  initial begin
    bit      hold_done;
    bit      pause_done;
    int      r;
    byte_q_t q;
    hold_done         = 1'b0;
    pause_done        = 1'b0;
    calm              = 1'b0;
    hold_req          = 1'b0;
    packets_sent      = 0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.code_index  = '0;
    in_ch.first_byte  = '0;
    in_ch.second_byte = '0;
    in_ch.third_byte  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: pressure extremes, ignored codes
    send_packet(CI_PRESSURE, 8'hFF, 8'h00, 8'hFF);
    send_packet(CI_PRESSURE, 8'h00, 8'hFF, 8'h00);
    send_packet(CI_PRESSURE, 8'h55, 8'h7A, 8'hAA);
    send_packet(4'h0, 8'h00, 8'h00, 8'h00);
    send_packet(4'hF, 8'hFF, 8'hFF, 8'hFF);
    // end packets while idle
    send_packet(CI_END3, SYSEX_START, STRIP_CMD, 8'h00);
    send_packet(CI_END1, SYSEX_START, 8'hFF, 8'hFF);
    send_packet(CI_END2, SYSEX_START, STRIP_CMD, 8'h00);
    // short message: header and base only
    send_sysex(strip_message(0, 0, 1'b0, 1'b0), 1'b0);
    // smallest strip address, terminated
    send_sysex(strip_message(0, 3, 1'b1, 1'b0), 1'b0);
    // runs off the end of the strip, no terminator
    send_sysex(strip_message(110, 4, 1'b0, 1'b0), 1'b0);
    // terminator right after the base address
    send_sysex(strip_message(5, 0, 1'b1, 1'b0), 1'b0);
    wait_drained();

    // random: mostly well formed messages, some noise and broken framing
    while (packets_sent < RANDOM_ITEMS) begin
      calm = (packets_sent >= 70 && packets_sent < 90);
      if (!hold_done && packets_sent >= 30) begin
        // long receiver hold-off over an overflowing message
        hold_done = 1'b1;
        hold_req  = 1'b1;
        q = strip_message(50, 70, 1'b1, 1'b0);
        send_sysex(q, 1'b0);
        send_pressure();
        send_pressure();
      end else if (!pause_done && packets_sent >= 60) begin
        pause_done = 1'b1;
        wait_drained();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60)      send_random_message(1'b0);
        else if (r < 72) send_pressure();
        else if (r < 82) send_noise();
        else if (r < 88) send_packet(CI_SYSEX_CONT, 8'($urandom), 8'($urandom),
                                     8'($urandom));
        else if (r < 94) send_packet(4'($urandom_range(CI_END1, CI_END3)), 8'($urandom),
                                     8'($urandom), 8'($urandom));
        else             send_random_message(1'b1);
      end
    end
    calm = 1'b0;

    // drain
    in_ch.valid <= 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && expected_left == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: usb_midi_sysex_strip_writer.f
src/usmsw_pkg.sv
src/usmsw_in_if.sv
src/usmsw_out_if.sv
src/usmsw_ctrl.sv
src/usmsw_dp.sv
src/usb_midi_sysex_strip_writer.sv
dv/usmsw_result_checker.sv
dv/tb_usb_midi_sysex_strip_writer.sv
